/* rtl/tkst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkst_pkg
// Shared types, constants and reset values for the top-k sorted insert table.
// ----------------------------------------------------------------------------
package tkst_pkg;

  localparam int ENTRIES = 10;
  localparam int IDX_W   = $clog2(ENTRIES);

  localparam int MODE_W  = 2;
  localparam int SCORE_W = 24;
  localparam int ROWS_W  = 16;
  localparam int LEVEL_W = 4;
  localparam int DATE_W  = 27;
  localparam int RIDX_W  = 4;
  localparam int SLOT_W  = 4;

  localparam int RESET_STEP  = 500;
  localparam int RESET_LEVEL = 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_QUERY  = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_READ   = 2'd2
  } mode_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [ROWS_W-1:0]  rows;
    logic [LEVEL_W-1:0] level;
    logic [DATE_W-1:0]  date;
  } rec_t;

  // Record held by a slot that has not been written since reset.
  function automatic rec_t reset_rec(input logic [IDX_W-1:0] addr);
    rec_t r;
    r.score = SCORE_W'((ENTRIES - int'(addr)) * RESET_STEP);
    r.rows  = '0;
    r.level = LEVEL_W'(RESET_LEVEL);
    r.date  = '0;
    return r;
  endfunction

endpackage

/* rtl/top_k_sorted_insert_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_sorted_insert_table
// Table of ENTRIES records sorted by descending score with query, insert and
// read commands, built around one comparator and one small memory.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; exactly one result
// follows as a single-cycle out_valid pulse that cannot be stalled, so the
// receiver must capture it on that cycle. A query or insert walks the slots
// from the top with a single score comparator, one slot per cycle, through a
// memory with a registered read port; an insert then moves the lower records
// down one slot per cycle and writes the new record. After the transfer, busy
// stays high while a read, query or insert is carried out; it does not rise
// for an unused mode or an out-of-range read index. The result pulse comes in
// the first cycle with busy low again, which is the cycle right after the
// transfer when busy never rose, and the next command may transfer in that
// same cycle. Unwritten slots read as their reset record.
// ----------------------------------------------------------------------------
module top_k_sorted_insert_table
  import tkst_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [MODE_W-1:0]  in_mode,
  input  logic [SCORE_W-1:0] in_score,
  input  logic [ROWS_W-1:0]  in_rows,
  input  logic [LEVEL_W-1:0] in_level,
  input  logic [DATE_W-1:0]  in_date,
  input  logic [RIDX_W-1:0]  in_read_index,
  output logic               out_valid,
  output logic               out_qualifies,
  output logic [SLOT_W-1:0]  out_slot,
  output logic [SCORE_W-1:0] out_entry_score,
  output logic [ROWS_W-1:0]  out_entry_rows,
  output logic [LEVEL_W-1:0] out_entry_level,
  output logic [DATE_W-1:0]  out_entry_date
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_SHIFT = 5'b00100,
    ST_PUT   = 5'b01000,
    ST_READ  = 5'b10000
  } state_t;

  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(ENTRIES - 1);
  localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(ENTRIES);

  state_t state_r, state_nxt;

  // Command registers
  mode_t              mode_r;
  rec_t               new_r;
  logic [IDX_W-1:0]   scan_r, scan_nxt;
  logic [IDX_W-1:0]   ptr_r, ptr_nxt;
  logic [IDX_W-1:0]   hit_r, hit_nxt;

  // Table memory
  rec_t               mem_r [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  rec_t               rd_data_r;
  logic               rd_vld_r;
  logic [IDX_W-1:0]   rd_addr_r;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  rec_t               wr_data;
  rec_t               rd_rec;

  // Result
  logic               emit;
  logic               emit_q;
  logic [SLOT_W-1:0]  emit_slot;
  rec_t               emit_rec;
  logic               out_valid_r;
  logic               out_q_r;
  logic [SLOT_W-1:0]  out_slot_r;
  rec_t               out_rec_r;

  logic               accept;
  logic               idx_ok;
  logic               score_lt;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign idx_ok = (int'(in_read_index) < ENTRIES);

  assign rd_rec   = rd_vld_r ? rd_data_r : reset_rec(rd_addr_r);
  // Shared comparator: stored score strictly below the command score
  assign score_lt = (rd_rec.score < new_r.score);

  always_comb begin
    state_nxt = state_r;
    scan_nxt  = scan_r;
    ptr_nxt   = ptr_r;
    hit_nxt   = hit_r;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = ptr_r;
    wr_data   = rd_rec;
    emit      = 1'b0;
    emit_q    = 1'b0;
    emit_slot = SLOT_NONE;
    emit_rec  = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          scan_nxt = '0;
          priority case (mode_t'(in_mode))
            MODE_QUERY, MODE_INSERT: begin
              rd_addr   = '0;
              state_nxt = ST_SCAN;
            end
            MODE_READ: begin
              if (idx_ok) begin
                rd_addr   = IDX_W'(in_read_index);
                state_nxt = ST_READ;
              end else begin
                emit = 1'b1;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (score_lt) begin
          hit_nxt = scan_r;
          if (mode_r == MODE_QUERY) begin
            emit      = 1'b1;
            emit_q    = 1'b1;
            emit_slot = SLOT_W'(scan_r);
            state_nxt = ST_IDLE;
          end else if (scan_r == LAST_IDX) begin
            state_nxt = ST_PUT;
          end else begin
            ptr_nxt   = LAST_IDX;
            rd_addr   = IDX_W'(ENTRIES - 2);
            state_nxt = ST_SHIFT;
          end
        end else if (scan_r == LAST_IDX) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          scan_nxt = scan_r + IDX_W'(1);
          rd_addr  = scan_r + IDX_W'(1);
        end
      end
      ST_SHIFT: begin
        // Move the record read from ptr-1 down into ptr
        wr_en   = 1'b1;
        wr_addr = ptr_r;
        wr_data = rd_rec;
        if ((ptr_r - IDX_W'(1)) == hit_r) begin
          state_nxt = ST_PUT;
        end else begin
          ptr_nxt = ptr_r - IDX_W'(1);
          rd_addr = ptr_r - IDX_W'(2);
        end
      end
      ST_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = hit_r;
        wr_data   = new_r;
        emit      = 1'b1;
        emit_q    = 1'b1;
        emit_slot = SLOT_W'(hit_r);
        state_nxt = ST_IDLE;
      end
      ST_READ: begin
        emit      = 1'b1;
        emit_q    = 1'b1;
        emit_slot = SLOT_W'(rd_addr_r);
        emit_rec  = rd_rec;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  // Command and sequencing registers
  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
    ptr_r  <= ptr_nxt;
    hit_r  <= hit_nxt;
    if (accept) begin
      mode_r      <= mode_t'(in_mode);
      new_r.score <= in_score;
      new_r.rows  <= in_rows;
      new_r.level <= in_level;
      new_r.date  <= in_date;
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
    rd_vld_r  <= valid_r[rd_addr];
    rd_addr_r <= rd_addr;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_q_r    <= emit_q;
      out_slot_r <= emit_slot;
      out_rec_r  <= emit_rec;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_qualifies   = out_q_r;
  assign out_slot        = out_slot_r;
  assign out_entry_score = out_rec_r.score;
  assign out_entry_rows  = out_rec_r.rows;
  assign out_entry_level = out_rec_r.level;
  assign out_entry_date  = out_rec_r.date;

endmodule

/* verif/top_k_sorted_insert_table_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_sorted_insert_table_test
// Self-checking bench for the sorted top-k record table. A driver feeds query,
// insert, read and unused-mode commands through the start/busy handshake.
// A monitor compares every result pulse against a scoreboard model of the
// table, which is updated as each command transfers.
// ----------------------------------------------------------------------------
module top_k_sorted_insert_table_test;
  import tkst_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int RANDOM_CMDS  = 600;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRINT_CAP    = 30;
  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [SCORE_W-1:0] score;
    logic [ROWS_W-1:0]  rows;
    logic [LEVEL_W-1:0] level;
    logic [DATE_W-1:0]  date;
    logic [RIDX_W-1:0]  ridx;
    bit                 drain_first;
  } cmd_t;

  typedef struct {
    logic              qualifies;
    logic [SLOT_W-1:0] slot;
    rec_t              rec;
  } answer_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [MODE_W-1:0]  in_mode = '0;
  logic [SCORE_W-1:0] in_score = '0;
  logic [ROWS_W-1:0]  in_rows = '0;
  logic [LEVEL_W-1:0] in_level = '0;
  logic [DATE_W-1:0]  in_date = '0;
  logic [RIDX_W-1:0]  in_read_index = '0;
  logic               out_valid;
  logic               out_qualifies;
  logic [SLOT_W-1:0]  out_slot;
  logic [SCORE_W-1:0] out_entry_score;
  logic [ROWS_W-1:0]  out_entry_rows;
  logic [LEVEL_W-1:0] out_entry_level;
  logic [DATE_W-1:0]  out_entry_date;

  top_k_sorted_insert_table DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_score        (in_score),
    .in_rows         (in_rows),
    .in_level        (in_level),
    .in_date         (in_date),
    .in_read_index   (in_read_index),
    .out_valid       (out_valid),
    .out_qualifies   (out_qualifies),
    .out_slot        (out_slot),
    .out_entry_score (out_entry_score),
    .out_entry_rows  (out_entry_rows),
    .out_entry_level (out_entry_level),
    .out_entry_date  (out_entry_date)
  );

  rec_t               board [ENTRIES];
  cmd_t               cmds_pending [$];
  answer_t            answers_due [$];
  logic [SCORE_W-1:0] recent_scores [8];
  int                 recent_ptr = 0;
  int                 err_count = 0;
  int                 cycle_count = 0;
  int                 gap_left = 0;
  bit                 took_item = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Scoreboard model: returns the answer and applies any insert to the board.
  function automatic answer_t apply_command(input cmd_t c);
    answer_t a;
    int      k;
    int      j;
    a.qualifies = 1'b0;
    a.slot      = SLOT_W'(ENTRIES);
    a.rec       = '0;
    case (c.mode)
      MODE_QUERY, MODE_INSERT: begin
        k = ENTRIES;
        for (j = ENTRIES - 1; j >= 0; j--)
          if (board[j].score < c.score) k = j;
        if (k < ENTRIES) begin
          a.qualifies = 1'b1;
          a.slot      = SLOT_W'(k);
          if (c.mode == MODE_INSERT) begin
            for (j = ENTRIES - 1; j > k; j--) board[j] = board[j-1];
            board[k] = '{score: c.score, rows: c.rows, level: c.level, date: c.date};
          end
        end
      end
      MODE_READ: begin
        if (c.ridx < ENTRIES) begin
          a.qualifies = 1'b1;
          a.slot      = SLOT_W'(c.ridx);
          a.rec       = board[c.ridx];
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      err_count++;
      if (err_count <= PRINT_CAP)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Monitor: check result pulses first, then record any command transfer.
  always @(posedge clk) begin
    answer_t a;
    cmd_t    c;
    if (rst_n && out_valid) begin
      if (answers_due.size() == 0) begin
        err_count++;
        if (err_count <= PRINT_CAP)
          $display("%0t: result with nothing expected, slot %0d", $time, out_slot);
      end else begin
        a = answers_due.pop_front();
        check_field("qualifies", a.qualifies, out_qualifies);
        check_field("slot", a.slot, out_slot);
        check_field("entry_score", a.rec.score, out_entry_score);
        check_field("entry_rows", a.rec.rows, out_entry_rows);
        check_field("entry_level", a.rec.level, out_entry_level);
        check_field("entry_date", a.rec.date, out_entry_date);
      end
    end
    took_item = rst_n && start && !busy;
    if (took_item) begin
      c.mode        = in_mode;
      c.score       = in_score;
      c.rows        = in_rows;
      c.level       = in_level;
      c.date        = in_date;
      c.ridx        = in_read_index;
      c.drain_first = 1'b0;
      answers_due.push_back(apply_command(c));
    end
  end

  // Driver: present the next command once the current one has transferred.
  always @(negedge clk) begin
    cmd_t nxt;
    bit   idle_ok;
    if (rst_n && (!start || took_item)) begin
      // keep a long idle-free stretch now and then, and a tail with no gaps
      idle_ok = (cmds_pending.size() > 40) && ((cmds_pending.size() % 160) > 50);
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left = gap_left - 1;
      end else if (cmds_pending.size() == 0) begin
        start <= 1'b0;
      end else if (cmds_pending[0].drain_first && answers_due.size() != 0) begin
        start <= 1'b0;
      end else begin
        nxt = cmds_pending.pop_front();
        in_mode       <= nxt.mode;
        in_score      <= nxt.score;
        in_rows       <= nxt.rows;
        in_level      <= nxt.level;
        in_date       <= nxt.date;
        in_read_index <= nxt.ridx;
        start         <= 1'b1;
        if (idle_ok && $urandom_range(3) == 0) gap_left = $urandom_range(1, 12);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic add_cmd(input logic [MODE_W-1:0] mode, input logic [SCORE_W-1:0] score,
                         input logic [ROWS_W-1:0] rows, input logic [LEVEL_W-1:0] level,
                         input logic [DATE_W-1:0] date, input logic [RIDX_W-1:0] ridx);
    cmd_t c;
    c = '{mode, score, rows, level, date, ridx, 1'b0};
    cmds_pending.push_back(c);
  endtask

  // Scores follow a rising ceiling so late inserts keep entering the table;
  // reuse of recent scores exercises ties.
  function automatic cmd_t random_cmd(input int n);
    cmd_t c;
    int   pick;
    int   ceil_val;
    ceil_val = 6000 + n * 28000;
    if (ceil_val > int'(SCORE_MAX)) ceil_val = int'(SCORE_MAX);
    pick = $urandom_range(99);
    if (pick < 40)      c.mode = MODE_INSERT;
    else if (pick < 65) c.mode = MODE_QUERY;
    else if (pick < 92) c.mode = MODE_READ;
    else                c.mode = MODE_SPARE;
    pick = $urandom_range(99);
    if (pick < 3)       c.score = SCORE_W'($urandom());
    else if (pick < 4)  c.score = SCORE_MAX;
    else if (pick < 5)  c.score = '0;
    else if (pick < 35) c.score = recent_scores[$urandom_range(7)];
    else if (pick < 70) c.score = SCORE_W'($urandom_range(ceil_val));
    else                c.score = SCORE_W'(ceil_val - $urandom_range(3000));
    recent_scores[recent_ptr] = c.score;
    recent_ptr = (recent_ptr + 1) % 8;
    c.rows  = ROWS_W'($urandom());
    c.level = LEVEL_W'($urandom());
    c.date  = ($urandom_range(99) < 85) ? DATE_W'($urandom_range(99991231))
                                        : DATE_W'($urandom());
    c.ridx  = ($urandom_range(99) < 85) ? RIDX_W'($urandom_range(ENTRIES - 1))
                                        : RIDX_W'($urandom_range(15));
    c.drain_first = 1'b0;
    return c;
  endfunction

  initial begin
    cmd_t c;
    int   i;
    for (i = 0; i < ENTRIES; i++) begin
      board[i].score = SCORE_W'((ENTRIES - i) * RESET_STEP);
      board[i].rows  = '0;
      board[i].level = LEVEL_W'(RESET_LEVEL);
      board[i].date  = '0;
    end
    for (i = 0; i < 8; i++) recent_scores[i] = SCORE_W'((i + 1) * RESET_STEP);

    // directed: reset contents, ties, misses, extremes, spare mode
    add_cmd(MODE_READ, '0, '0, '0, '0, '0);
    add_cmd(MODE_READ, '0, '0, '0, '0, RIDX_W'(ENTRIES - 1));
    add_cmd(MODE_READ, '0, '0, '0, '0, RIDX_W'(ENTRIES));
    add_cmd(MODE_READ, '0, '0, '0, '0, '1);
    add_cmd(MODE_QUERY, '0, '0, '0, '0, '0);
    add_cmd(MODE_QUERY, SCORE_W'(ENTRIES * RESET_STEP), '0, '0, '0, '0);
    add_cmd(MODE_QUERY, SCORE_MAX, '0, '0, '0, '0);
    add_cmd(MODE_QUERY, SCORE_W'(RESET_STEP + 1), '0, '0, '0, '0);
    add_cmd(MODE_QUERY, SCORE_W'(RESET_STEP), '0, '0, '0, '0);
    add_cmd(MODE_INSERT, SCORE_W'(RESET_STEP), 16'h0001, 4'h2, 27'd3, '0);
    add_cmd(MODE_INSERT, '0, '1, '1, '1, '1);
    add_cmd(MODE_INSERT, SCORE_MAX, '1, '1, '1, '0);
    add_cmd(MODE_INSERT, SCORE_W'(ENTRIES * RESET_STEP), 16'h1234, 4'hA, 27'd99991231, '0);
    add_cmd(MODE_INSERT, SCORE_W'(RESET_STEP + 1), 16'h0007, '0, '0, '0);
    add_cmd(MODE_SPARE, SCORE_MAX, '1, '1, '1, '1);
    add_cmd(MODE_READ, '0, '0, '0, '0, 4'd0);
    add_cmd(MODE_READ, '0, '0, '0, '0, 4'd1);
    add_cmd(MODE_READ, '0, '0, '0, '0, 4'd2);
    add_cmd(MODE_READ, '0, '0, '0, '0, 4'd3);
    add_cmd(MODE_READ, '0, '0, '0, '0, RIDX_W'(ENTRIES - 2));
    add_cmd(MODE_READ, '0, '0, '0, '0, RIDX_W'(ENTRIES - 1));
    add_cmd(MODE_QUERY, SCORE_MAX, '0, '0, '0, '0);

    for (i = 0; i < RANDOM_CMDS; i++) begin
      c = random_cmd(i);
      c.drain_first = (i == 0) || (i == RANDOM_CMDS / 2);
      cmds_pending.push_back(c);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmds_pending.size() != 0 || start) @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);

    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
